/* hdl/vlc_pkg.sv */
// vlc_pkg: widths, stage counts and shared types for vector_length_clamp_3d
// no dependencies
package vlc_pkg;

	localparam int COMP_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int SUM_W     = 2 * COMP_W;
	localparam int ROOT_W    = COMP_W;
	localparam int DIV_STEPS = COMP_W;
	localparam int NSTG      = 3 + ROOT_W + 1 + DIV_STEPS + 1;

	typedef enum logic [1:0] {
		FN_TRUNC = 2'd0,
		FN_NORM  = 2'd1,
		FN_MAG   = 2'd2,
		FN_RSVD  = 2'd3
	} func_t;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic [COMP_W-1:0] ucomp_t;

	typedef struct packed {
		logic [1:0] func;
		comp_t [2:0] c;
		ucomp_t ml;
	} side_t;

	typedef struct packed {
		logic [1:0] func;
		comp_t [2:0] c;
		ucomp_t len;
		logic clamp;
		logic zero;
	} tail_t;

endpackage

/* hdl/vector_length_clamp_3d.sv */
// vector_length_clamp_3d: magnitude, clamp and normalize of a signed Q8.8 3D vector
// one beat per cycle sustained while the output beat is not stalled
// 16-stage root pipeline and three 16-stage divider lanes set the depth
// whole pipeline holds while the output beat is stalled
// reset clears the stage valid bits only; depends on vlc_pkg, vlc_divider
module vector_length_clamp_3d (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] func,
	input  vlc_pkg::comp_t in_x,
	input  vlc_pkg::comp_t in_y,
	input  vlc_pkg::comp_t in_z,
	input  vlc_pkg::ucomp_t max_len,
	output logic out_valid,
	input  logic out_stall,
	output vlc_pkg::comp_t out_x,
	output vlc_pkg::comp_t out_y,
	output vlc_pkg::comp_t out_z,
	output vlc_pkg::ucomp_t length,
	output logic was_clamped,
	output logic zero_input
);
	import vlc_pkg::*;

	logic adv;
	logic [NSTG-1:0] vld_q;

	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	// stage 1: absolute values
	side_t side_s1;
	ucomp_t [2:0] a_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= '{func: func, c: {in_z, in_y, in_x}, ml: max_len};
			a_s1[0] <= in_x[COMP_W-1] ? ucomp_t'(-in_x) : ucomp_t'(in_x);
			a_s1[1] <= in_y[COMP_W-1] ? ucomp_t'(-in_y) : ucomp_t'(in_y);
			a_s1[2] <= in_z[COMP_W-1] ? ucomp_t'(-in_z) : ucomp_t'(in_z);
		end
	end

	// stage 2: squares
	side_t side_s2;
	logic [2:0][SUM_W-1:0] sq_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			for (int i = 0; i < 3; i++) sq_s2[i] <= a_s1[i] * a_s1[i];
		end
	end

	// stage 3: sum of squares
	side_t side_s3;
	logic [SUM_W-1:0] sum_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// root pipeline, one result bit per stage
	side_t side_rs [ROOT_W+1];
	logic [SUM_W-1:0] rem_rs [ROOT_W+1];
	ucomp_t root_rs [ROOT_W+1];
	assign side_rs[0] = side_s3;
	assign rem_rs[0] = sum_s3;
	assign root_rs[0] = '0;

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
		localparam int B = ROOT_W - k;
		logic [SUM_W-1:0] t;
		logic ge;
		assign t = ({{(SUM_W-ROOT_W){1'b0}}, root_rs[k-1]} << (B + 1))
			+ ({{(SUM_W-1){1'b0}}, 1'b1} << (2 * B));
		assign ge = rem_rs[k-1] >= t;
		always_ff @(posedge clk) begin
			if (adv) begin
				side_rs[k] <= side_rs[k-1];
				rem_rs[k] <= ge ? rem_rs[k-1] - t : rem_rs[k-1];
				root_rs[k] <= root_rs[k-1] | ({{(ROOT_W-1){1'b0}}, ge} << B);
			end
		end
	end

	// product stage: scale numerator times component magnitude
	side_t sr;
	ucomp_t len_c;
	ucomp_t num_c;
	assign sr = side_rs[ROOT_W];
	assign len_c = root_rs[ROOT_W];
	assign num_c = (sr.func == FN_NORM) ? ucomp_t'(1 << FRAC_BITS) : sr.ml;

	tail_t tail_sp;
	logic [2:0][SUM_W-1:0] prod_sp;
	always_ff @(posedge clk) begin
		if (adv) begin
			tail_sp <= '{func: sr.func, c: sr.c, len: len_c,
				clamp: (sr.func == FN_TRUNC) && (len_c > sr.ml), zero: len_c == '0};
			for (int i = 0; i < 3; i++)
				prod_sp[i] <= (sr.c[i][COMP_W-1] ? ucomp_t'(-sr.c[i]) : ucomp_t'(sr.c[i]))
					* num_c;
		end
	end

	// divider lanes with matching tail delay
	logic [2:0][DIV_STEPS-1:0] quo;
	for (genvar i = 0; i < 3; i++) begin : g_lane
		vlc_divider u_div (
			.clk(clk), .adv(adv), .dividend(prod_sp[i]),
			.divisor(tail_sp.len), .quotient(quo[i])
		);
	end

	tail_t tail_ds [DIV_STEPS+1];
	assign tail_ds[0] = tail_sp;
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_tail
		always_ff @(posedge clk) begin
			if (adv) tail_ds[k] <= tail_ds[k-1];
		end
	end

	// output stage: sign, select, saturate
	tail_t td;
	comp_t [2:0] res_c;
	assign td = tail_ds[DIV_STEPS];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [COMP_W:0] qs;
			qs = {1'b0, quo[i]};
			if (!td.c[i][COMP_W-1] && quo[i][COMP_W-1]) qs = {2'b0, {(COMP_W-1){1'b1}}};
			if (td.c[i][COMP_W-1]) qs = -qs;
			case (td.func)
				FN_TRUNC: res_c[i] = td.clamp ? comp_t'(qs[COMP_W-1:0]) : td.c[i];
				FN_NORM:  res_c[i] = td.zero ? '0 : comp_t'(qs[COMP_W-1:0]);
				default:  res_c[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x <= res_c[0];
			out_y <= res_c[1];
			out_z <= res_c[2];
			length <= td.len;
			was_clamped <= td.clamp;
			zero_input <= td.zero;
		end
	end

	a_zero_no_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_input |-> !was_clamped && length == '0)
		else $error("zero vector reported as clamped");
	a_zero_outs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_input |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("zero vector gave nonzero result");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length <= 16'd56756)
		else $error("magnitude out of range");

endmodule

/* hdl/vlc_divider.sv */
// vlc_divider: pipelined restoring divider, one quotient bit per stage
// depends on vlc_pkg; quotient must fit in DIV_STEPS bits
module vlc_divider (
	input  logic clk,
	input  logic adv,
	input  logic [vlc_pkg::SUM_W-1:0] dividend,
	input  logic [vlc_pkg::ROOT_W-1:0] divisor,
	output logic [vlc_pkg::DIV_STEPS-1:0] quotient
);
	import vlc_pkg::*;

	logic [SUM_W-1:0] rem_s [DIV_STEPS+1];
	logic [ROOT_W-1:0] den_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] q_s [DIV_STEPS+1];

	assign rem_s[0] = dividend;
	assign den_s[0] = divisor;
	assign q_s[0] = '0;

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		localparam int B = DIV_STEPS - k;
		logic [SUM_W-1:0] t;
		logic ge;
		assign t = {{(SUM_W-ROOT_W){1'b0}}, den_s[k-1]} << B;
		assign ge = rem_s[k-1] >= t;
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? rem_s[k-1] - t : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				q_s[k] <= q_s[k-1] | ({{(DIV_STEPS-1){1'b0}}, ge} << B);
			end
		end
	end

	assign quotient = q_s[DIV_STEPS];

endmodule

/* sim/vector_length_clamp_3d_check.sv */
// vector_length_clamp_3d_check: watches both channels of vector_length_clamp_3d,
// predicts each result beat and compares it field by field; depends on vlc_pkg
module vector_length_clamp_3d_check (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [1:0] func,
	input  vlc_pkg::comp_t in_x,
	input  vlc_pkg::comp_t in_y,
	input  vlc_pkg::comp_t in_z,
	input  vlc_pkg::ucomp_t max_len,
	input  logic out_valid,
	input  logic out_stall,
	input  vlc_pkg::comp_t out_x,
	input  vlc_pkg::comp_t out_y,
	input  vlc_pkg::comp_t out_z,
	input  vlc_pkg::ucomp_t length,
	input  logic was_clamped,
	input  logic zero_input,
	output int fail_count,
	output int pending
);
	import vlc_pkg::*;

	typedef struct packed {
		comp_t x, y, z;
		ucomp_t len;
		logic clamp;
		logic zero;
	} clamp_res_t;

	clamp_res_t expected_q[$];

	function automatic logic [15:0] floor_root(logic [47:0] n);
		logic [47:0] r;
		logic [47:0] b;
		r = 0;
		b = 48'd1 << 46;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[15:0];
	endfunction

	// sign(v) * trunc(|v| * num / den), saturated
	function automatic comp_t scale_comp(comp_t v, logic [31:0] num, logic [31:0] den);
		logic [63:0] m;
		logic [63:0] q;
		m = (v < 0) ? 64'(-32'(v)) : 64'(v);
		q = (den != 0) ? (m * num) / den : 0;
		if (v < 0) begin
			if (q > 32768)
				q = 32768;
			return comp_t'(-q);
		end
		if (q > 32767)
			q = 32767;
		return comp_t'(q);
	endfunction

	function automatic clamp_res_t predict_clamp(logic [1:0] f, comp_t x, comp_t y, comp_t z,
			ucomp_t ml);
		clamp_res_t r;
		logic [47:0] s;
		comp_t c[3];
		comp_t o[3];
		c[0] = x;
		c[1] = y;
		c[2] = z;
		s = 0;
		for (int i = 0; i < 3; i++)
			s = s + 48'(32'(c[i]) * 32'(c[i]));
		r.len = floor_root(s);
		r.clamp = 0;
		for (int i = 0; i < 3; i++) begin
			o[i] = 0;
			if (f == FN_TRUNC) begin
				if (r.len > ml) begin
					o[i] = scale_comp(c[i], ml, r.len);
					r.clamp = 1;
				end else begin
					o[i] = c[i];
				end
			end else if (f == FN_NORM) begin
				o[i] = scale_comp(c[i], 32'd1 << FRAC_BITS, r.len);
			end
		end
		r.x = o[0];
		r.y = o[1];
		r.z = o[2];
		r.zero = (r.len == 0);
		return r;
	endfunction

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk) begin
		clamp_res_t e;
		if (arst_n && in_valid && !in_stall)
			expected_q.push_back(predict_clamp(func, in_x, in_y, in_z, max_len));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result beat x=%0d y=%0d z=%0d", out_x, out_y, out_z);
			end else begin
				e = expected_q.pop_front();
				if (e.x !== out_x || e.y !== out_y || e.z !== out_z || e.len !== length
						|| e.clamp !== was_clamped || e.zero !== zero_input) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch exp %0d %0d %0d len %0d c%0b z%0b",
							" got %0d %0d %0d len %0d c%0b z%0b"},
							e.x, e.y, e.z, e.len, e.clamp, e.zero,
							out_x, out_y, out_z, length, was_clamped, zero_input);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

/* sim/vector_length_clamp_3d_test.sv */
// vector_length_clamp_3d_test: stimulus, idling and verdict for vector_length_clamp_3d
// depends on vlc_pkg, the block and vector_length_clamp_3d_check
module vector_length_clamp_3d_test;
	import vlc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] func = FN_TRUNC;
	comp_t in_x = 0;
	comp_t in_y = 0;
	comp_t in_z = 0;
	ucomp_t max_len = 0;
	logic out_valid;
	logic out_stall = 0;
	comp_t out_x, out_y, out_z;
	ucomp_t length;
	logic was_clamped, zero_input;
	int fail_count, pending;
	int cycles = 0;
	logic sink_run = 0;

	always #4 clk = ~clk;

	vector_length_clamp_3d u_dut (.*);

	vector_length_clamp_3d_check u_check (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// output stall: phases with no stall alternate with phases of random stalls
	always @(posedge clk) begin
		if (sink_run) begin
			if ((cycles / 500) % 3 == 0)
				out_stall <= 0;
			else
				out_stall <= (gap_len() != 0);
		end
	end

	function automatic comp_t rnd_comp();
		case ($urandom_range(0, 5))
			0: return comp_t'(16'h8000);
			1: return comp_t'(16'h7fff);
			2: return comp_t'($urandom_range(0, 64) - 32);
			3: return comp_t'($urandom_range(0, 2048) - 1024);
			default: return comp_t'($urandom());
		endcase
	endfunction

	task automatic send_beat(logic [1:0] f, comp_t x, comp_t y, comp_t z, ucomp_t ml);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		max_len <= ml;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		logic [1:0] f;
		comp_t x, y, z;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		sink_run <= 1;
		@(posedge clk);
		send_beat(FN_TRUNC, 0, 0, 0, 0);
		send_beat(FN_NORM, 0, 0, 0, 100);
		send_beat(FN_MAG, 0, 0, 0, 0);
		send_beat(FN_RSVD, 300, -16'sd400, 0, 0);
		send_beat(FN_TRUNC, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
		send_beat(FN_TRUNC, 16'sh8000, 16'sh8000, 16'sh8000, 0);
		send_beat(FN_TRUNC, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
		send_beat(FN_TRUNC, 768, 1024, 0, 1280);
		send_beat(FN_TRUNC, 768, 1024, 0, 1279);
		send_beat(FN_TRUNC, -16'sd768, 0, 1024, 0);
		send_beat(FN_NORM, 16'sh8000, 0, 0, 0);
		send_beat(FN_NORM, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
		send_beat(FN_NORM, 1, 0, 0, 0);
		send_beat(FN_NORM, 0, -16'sd1, 1, 0);
		send_beat(FN_MAG, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
		send_beat(FN_RSVD, 16'sh7fff, -16'sd1, 5, 16'haaaa);
		send_beat(FN_TRUNC, 1, 1, 1, 16'h5555);
		for (int i = 0; i < 1030; i++) begin
			if (i == 500) begin
				in_valid <= 0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			f = 2'($urandom_range(0, 3));
			x = rnd_comp();
			y = rnd_comp();
			z = rnd_comp();
			send_beat(f, x, y, z, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) :
				16'($urandom()));
		end
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* vector_length_clamp_3d.f */
hdl/vlc_pkg.sv
hdl/vlc_divider.sv
hdl/vector_length_clamp_3d.sv
sim/vector_length_clamp_3d_check.sv
sim/vector_length_clamp_3d_test.sv
